/* rtl/blv_pkg.sv */
package blv_pkg;

    typedef enum logic [1:0] {
        OP_DATA = 2'd0,
        OP_FILE = 2'd1,
        OP_EOF  = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_BLANK  = 2'd1,
        KIND_HEADER = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_CHROM = 3'd0,
        PH_START = 3'd1,
        PH_END   = 3'd2,
        PH_SKIP  = 3'd3,
        PH_ID    = 3'd4,
        PH_REST  = 3'd5
    } phase_t;

    localparam logic [4:0] ERR_NONE        = 5'd0;
    localparam logic [4:0] ERR_TOO_LONG    = 5'd1;
    localparam logic [4:0] ERR_LEAD_SEP    = 5'd2;
    localparam logic [4:0] ERR_NO_SEP      = 5'd3;
    localparam logic [4:0] ERR_CHROM_LONG  = 5'd4;
    localparam logic [4:0] ERR_NO_SEP_START = 5'd5;
    localparam logic [4:0] ERR_START_BASE  = 5'd6;
    localparam logic [4:0] ERR_EOF_IN_END  = 5'd10;
    localparam logic [4:0] ERR_END_BASE    = 5'd11;
    localparam logic [4:0] ERR_END_LE      = 5'd15;
    localparam logic [4:0] ERR_ID_LONG     = 5'd16;

    localparam logic [2:0] CFG_LINE  = 3'd0;
    localparam logic [2:0] CFG_CHROM = 3'd1;
    localparam logic [2:0] CFG_DIG   = 3'd2;
    localparam logic [2:0] CFG_COORD = 3'd3;
    localparam logic [2:0] CFG_ID    = 3'd4;

    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_AT   = 8'h40;

    localparam logic [7:0] WORD_BROWSER [7] = '{8'h62, 8'h72, 8'h6F, 8'h77, 8'h73, 8'h65, 8'h72};
    localparam logic [7:0] WORD_TRACK [5] = '{8'h74, 8'h72, 8'h61, 8'h63, 8'h6B};

    // Decoded item passed from front to back
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
        logic       is_sep;
        logic       is_ws;
        logic       is_digit;
        logic [3:0] digit;
    } cls_t;

    typedef struct packed {
        logic [1:0]  line_kind;
        logic [4:0]  error_code;
        logic [31:0] line_number;
        logic [7:0]  chrom_length;
        logic [62:0] start_coord;
        logic [62:0] end_coord;
        logic        has_extra_fields;
        logic [7:0]  id_length;
    } res_t;

endpackage

/* rtl/blv_if.sv */
interface blv_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface blv_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  line_kind;
    logic [4:0]  error_code;
    logic [31:0] line_number;
    logic [7:0]  chrom_length;
    logic [62:0] start_coord;
    logic [62:0] end_coord;
    logic        has_extra_fields;
    logic [7:0]  id_length;
    modport source (output valid, output line_kind, output error_code, output line_number,
        output chrom_length, output start_coord, output end_coord,
        output has_extra_fields, output id_length, input ready);
    modport sink (input valid, input line_kind, input error_code, input line_number,
        input chrom_length, input start_coord, input end_coord,
        input has_extra_fields, input id_length, output ready);
endinterface

/* rtl/blv_front.sv */
module blv_front (
    input  logic         clk,
    input  logic         rst_n,
    blv_in_if.sink       in_ch,
    output logic         q_valid,
    input  logic         q_ready,
    output blv_pkg::cls_t q_data
);
    import blv_pkg::*;

    // two-entry queue of classified bytes
    cls_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    cls_t       cls;
    logic       push, pop;

    always_comb
    begin
        cls.opcode    = in_ch.opcode;
        cls.data_byte = in_ch.data_byte;
        cls.is_sep    = (in_ch.data_byte == CH_SP) || (in_ch.data_byte == CH_TAB);
        cls.is_ws     = cls.is_sep || (in_ch.data_byte == CH_VT) ||
                        (in_ch.data_byte == CH_FF) || (in_ch.data_byte == CH_CR);
        cls.is_digit  = (in_ch.data_byte >= 8'h30) && (in_ch.data_byte <= 8'h39);
        cls.digit     = 4'(in_ch.data_byte - 8'h30);
    end

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push    = in_ch.valid && in_ch.ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_data  = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop) rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !push) else $error("push into full queue");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count did not advance");
endmodule

/* rtl/blv_back.sv */
module blv_back #(
    parameter int LINE_COUNT_BITS = 32,
    parameter int COORD_BITS = 63
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  blv_pkg::cls_t q_data,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [62:0]   cfg_data,
    blv_out_if.source     out_ch
);
    import blv_pkg::*;

    localparam logic [63:0] U64MAX = '1;
    localparam logic [63:0] CAP = 64'((65'd1 << COORD_BITS) - 65'd1);
    localparam logic [LINE_COUNT_BITS-1:0] LC_MAX = '1;

    logic [15:0] max_line_reg;
    logic [7:0]  max_chrom_reg, max_id_reg;
    logic [4:0]  max_dig_reg;
    logic [62:0] max_coord_reg;

    phase_t      phase_reg, phase_next;
    logic        hdr_ok_reg, hdr_ok_next;
    logic [LINE_COUNT_BITS-1:0] lc_reg, lc_next;
    logic [15:0] lb_reg, lb_next;
    logic [7:0]  fb_reg, fb_next;
    logic [63:0] sv_reg, sv_next, ev_reg, ev_next;
    logic        nd_reg, nd_next;
    logic [1:0]  alive_reg, alive_next;
    logic [2:0]  pos_reg, pos_next;
    logic        hit_reg, hit_next;
    logic [4:0]  perr_reg, perr_next;
    logic        halt_reg, halt_next;
    logic        extra_reg, extra_next;
    logic [7:0]  idb_reg, idb_next;
    logic [7:0]  cl_reg, cl_next;

    res_t        res_reg, res_next;
    logic        ov_reg;
    logic        emit;
    logic        take;
    logic [63:0] limit;
    logic [63:0] cur_v, acc_v, mul10;
    logic [15:0] lb_inc;
    logic [LINE_COUNT_BITS-1:0] lc_bump;
    logic [4:0]  ccs, cce, fcode;
    logic [7:0]  b;

    assign limit = ({1'b0, max_coord_reg} < CAP) ? {1'b0, max_coord_reg} : CAP;
    assign q_ready = !ov_reg || out_ch.ready;
    assign take = q_valid && q_ready;
    assign b = q_data.data_byte;
    assign lb_inc = lb_reg + 16'd1;
    assign lc_bump = (lc_reg == LC_MAX) ? lc_reg : lc_reg + 1'b1;

    // coordinate check helpers
    function automatic logic [4:0] chk(input logic [4:0] base, input logic [63:0] v,
        input logic [7:0] fb, input logic nd, input logic [4:0] md, input logic [63:0] lim);
        if (fb > {3'b0, md}) return base;
        if (fb == 8'd0) return base + 5'd1;
        if (nd) return base + 5'd2;
        if (v > lim) return base + 5'd3;
        return ERR_NONE;
    endfunction

    // saturating times ten plus digit
    assign cur_v = (phase_reg == PH_START) ? sv_reg : ev_reg;
    assign mul10 = {cur_v[60:0], 3'b0} + {cur_v[62:0], 1'b0};
    always_comb
    begin
        if (cur_v > 64'd1844674407370955161 ||
            (cur_v == 64'd1844674407370955161 && q_data.digit > 4'd5))
            acc_v = U64MAX;
        else
            acc_v = mul10 + 64'(q_data.digit);
    end

    assign ccs = chk(ERR_START_BASE, sv_reg, fb_reg, nd_reg, max_dig_reg, limit);
    always_comb
    begin
        cce = chk(ERR_END_BASE, ev_reg, fb_reg, nd_reg, max_dig_reg, limit);
        if (cce == ERR_NONE && ev_reg <= sv_reg) cce = ERR_END_LE;
    end

    always_comb
    begin
        logic clr;
        logic fin;
        logic fin_eof;
        logic hdr;
        clr = 1'b0; fin = 1'b0; fin_eof = 1'b0; hdr = 1'b0;
        phase_next = phase_reg; hdr_ok_next = hdr_ok_reg; lc_next = lc_reg;
        lb_next = lb_reg; fb_next = fb_reg; sv_next = sv_reg; ev_next = ev_reg;
        nd_next = nd_reg; alive_next = alive_reg; pos_next = pos_reg; hit_next = hit_reg;
        perr_next = perr_reg; halt_next = halt_reg; extra_next = extra_reg;
        idb_next = idb_reg; cl_next = cl_reg;
        emit = 1'b0; res_next = res_reg; fcode = perr_reg;
        if (take)
        begin
            case (q_data.opcode)
                OP_FILE:
                begin
                    clr = 1'b1; lc_next = LINE_COUNT_BITS'(1); hdr_ok_next = 1'b1;
                    halt_next = 1'b0;
                end
                OP_EOF:
                begin
                    if (!halt_reg && lb_reg != 16'd0)
                    begin
                        fin = 1'b1; fin_eof = 1'b1;
                    end
                    halt_next = 1'b1; clr = 1'b1;
                end
                OP_DATA:
                begin
                    if (!halt_reg)
                    begin
                        if (b == CH_NL && lb_reg == 16'd0)
                        begin
                            emit = 1'b1;
                            res_next = '0;
                            res_next.line_kind = KIND_BLANK;
                            res_next.line_number = 32'(lc_reg);
                            lc_next = lc_bump;
                        end
                        else if (lb_inc >= max_line_reg)
                        begin
                            emit = 1'b1;
                            res_next = '0;
                            res_next.line_kind = KIND_ERROR;
                            res_next.error_code = ERR_TOO_LONG;
                            res_next.line_number = 32'(lc_reg);
                            halt_next = 1'b1; clr = 1'b1;
                        end
                        else if (b == CH_NL)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            lb_next = lb_inc;
                            // header prefix tracking
                            if (!hit_reg)
                            begin
                                if (pos_reg == 3'd0 && (b == CH_HASH || b == CH_AT))
                                    hit_next = 1'b1;
                                else
                                begin
                                    alive_next = alive_reg;
                                    if (pos_reg < 3'd7 && alive_reg[0] &&
                                        b != WORD_BROWSER[pos_reg])
                                        alive_next[0] = 1'b0;
                                    if (pos_reg < 3'd5 && alive_reg[1] &&
                                        b != WORD_TRACK[pos_reg])
                                        alive_next[1] = 1'b0;
                                    if (pos_reg < 3'd7) pos_next = pos_reg + 3'd1;
                                    if ((alive_next[0] && pos_next == 3'd7) ||
                                        (alive_next[1] && pos_next == 3'd5))
                                        hit_next = 1'b1;
                                end
                            end
                            if (perr_reg == ERR_NONE)
                            begin
                                case (phase_reg)
                                    PH_CHROM:
                                    begin
                                        if (q_data.is_sep)
                                        begin
                                            if (fb_reg == 8'd0) perr_next = ERR_LEAD_SEP;
                                            else if (fb_reg > max_chrom_reg)
                                                perr_next = ERR_CHROM_LONG;
                                            else
                                            begin
                                                cl_next = fb_reg; phase_next = PH_START;
                                                fb_next = 8'd0;
                                            end
                                        end
                                        else if (fb_reg != 8'hFF) fb_next = fb_reg + 8'd1;
                                    end
                                    PH_START, PH_END:
                                    begin
                                        if (q_data.is_sep)
                                        begin
                                            if (phase_reg == PH_START)
                                            begin
                                                if (ccs != ERR_NONE) perr_next = ccs;
                                                else phase_next = PH_END;
                                            end
                                            else
                                            begin
                                                if (cce != ERR_NONE) perr_next = cce;
                                                else phase_next = PH_SKIP;
                                            end
                                            fb_next = 8'd0; nd_next = 1'b0;
                                        end
                                        else
                                        begin
                                            if (fb_reg != 8'hFF) fb_next = fb_reg + 8'd1;
                                            if (q_data.is_digit)
                                            begin
                                                if (phase_reg == PH_START) sv_next = acc_v;
                                                else ev_next = acc_v;
                                            end
                                            else nd_next = 1'b1;
                                        end
                                    end
                                    PH_SKIP:
                                    begin
                                        if (!q_data.is_ws)
                                        begin
                                            extra_next = 1'b1; idb_next = 8'd1;
                                            phase_next = PH_ID;
                                        end
                                    end
                                    PH_ID:
                                    begin
                                        if (q_data.is_sep) phase_next = PH_REST;
                                        else if (idb_reg != 8'hFF) idb_next = idb_reg + 8'd1;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                    end
                end
                default: ;
            endcase
            // line completion
            if (fin)
            begin
                emit = 1'b1; clr = 1'b1;
                res_next = '0;
                res_next.line_number = 32'(lc_reg);
                hdr = hdr_ok_reg && hit_reg;
                if (hdr)
                begin
                    res_next.line_kind = KIND_HEADER;
                    lc_next = lc_bump;
                end
                else
                begin
                    if (fcode == ERR_NONE)
                    begin
                        case (phase_reg)
                            PH_CHROM: fcode = ERR_NO_SEP;
                            PH_START: fcode = ERR_NO_SEP_START;
                            PH_END:   fcode = fin_eof ? ERR_EOF_IN_END : cce;
                            default:  fcode = ERR_NONE;
                        endcase
                    end
                    if (fcode == ERR_NONE && extra_reg && idb_reg > max_id_reg)
                        fcode = ERR_ID_LONG;
                    if (fcode != ERR_NONE)
                    begin
                        res_next.line_kind = KIND_ERROR;
                        res_next.error_code = fcode;
                        halt_next = 1'b1;
                    end
                    else
                    begin
                        res_next.line_kind = KIND_DATA;
                        res_next.chrom_length = cl_reg;
                        res_next.start_coord = 63'(sv_reg & CAP);
                        res_next.end_coord = 63'(ev_reg & CAP);
                        res_next.has_extra_fields = extra_reg;
                        res_next.id_length = extra_reg ? idb_reg : 8'd0;
                        hdr_ok_next = 1'b0;
                        lc_next = lc_bump;
                    end
                end
            end
            if (clr)
            begin
                phase_next = PH_CHROM; lb_next = 16'd0; fb_next = 8'd0; sv_next = '0;
                ev_next = '0; nd_next = 1'b0; alive_next = 2'b11; pos_next = 3'd0;
                hit_next = 1'b0; perr_next = ERR_NONE; extra_next = 1'b0;
                idb_next = 8'd0; cl_next = 8'd0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_line_reg <= 16'd4096; max_chrom_reg <= 8'd127; max_dig_reg <= 5'd19;
            max_coord_reg <= '1; max_id_reg <= 8'd255;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LINE:  max_line_reg <= cfg_data[15:0];
                CFG_CHROM: max_chrom_reg <= cfg_data[7:0];
                CFG_DIG:   max_dig_reg <= cfg_data[4:0];
                CFG_COORD: max_coord_reg <= cfg_data;
                CFG_ID:    max_id_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CHROM; hdr_ok_reg <= 1'b1; lc_reg <= LINE_COUNT_BITS'(1);
            lb_reg <= '0; fb_reg <= '0; sv_reg <= '0; ev_reg <= '0; nd_reg <= 1'b0;
            alive_reg <= 2'b11; pos_reg <= '0; hit_reg <= 1'b0; perr_reg <= ERR_NONE;
            halt_reg <= 1'b0; extra_reg <= 1'b0; idb_reg <= '0; cl_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; hdr_ok_reg <= hdr_ok_next; lc_reg <= lc_next;
            lb_reg <= lb_next; fb_reg <= fb_next; sv_reg <= sv_next; ev_reg <= ev_next;
            nd_reg <= nd_next; alive_reg <= alive_next; pos_reg <= pos_next;
            hit_reg <= hit_next; perr_reg <= perr_next; halt_reg <= halt_next;
            extra_reg <= extra_next; idb_reg <= idb_next; cl_reg <= cl_next;
            if (emit) ov_reg <= 1'b1;
            else if (out_ch.ready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) res_reg <= res_next;
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.line_kind = res_reg.line_kind;
    assign out_ch.error_code = res_reg.error_code;
    assign out_ch.line_number = res_reg.line_number;
    assign out_ch.chrom_length = res_reg.chrom_length;
    assign out_ch.start_coord = res_reg.start_coord;
    assign out_ch.end_coord = res_reg.end_coord;
    assign out_ch.has_extra_fields = res_reg.has_extra_fields;
    assign out_ch.id_length = res_reg.id_length;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ch.ready) |-> !take) else $error("result overwritten");
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> ((res_reg.line_kind == KIND_ERROR) == (res_reg.error_code != ERR_NONE)))
        else $error("error code mismatch");
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (halt_reg && take && q_data.opcode == OP_DATA) |=> !$rose(ov_reg))
        else $error("result while halted");
endmodule

/* rtl/bed_line_validator.sv */
// BED line validator.
// in_ch carries one byte command per transfer (opcode: data byte, file start,
// file end, none); out_ch carries one result per completed line. Both use
// valid/ready; a transfer happens when both are high.
// cfg_we/cfg_index/cfg_data write the limit registers, one per cycle, and
// must be written only while the block is idle.
// Throughput: one byte per cycle while no result waits on out_ch. A front
// stage classifies bytes into a two-entry queue; the back stage updates the
// field state per taken byte (times-ten add on the coordinate accumulator)
// and registers the result once the closing byte leaves the front queue.
// Reset: limits return to their defaults, queue empties, line counter is 1
// and header lines are allowed, as at the start of a file.
// Stall: while a result waits on out_ch, the back stage holds; the queue
// absorbs up to two further bytes before in_ch.ready drops.
module bed_line_validator #(
    parameter int LINE_COUNT_BITS = 32,
    parameter int COORD_BITS = 63
) (
    input  logic        clk,
    input  logic        rst_n,
    blv_in_if.sink      in_ch,
    blv_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [62:0] cfg_data
);
    import blv_pkg::*;

    logic q_valid, q_ready;
    cls_t q_data;

    blv_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    blv_back #(.LINE_COUNT_BITS(LINE_COUNT_BITS), .COORD_BITS(COORD_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_data(q_data), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .out_ch(out_ch)
    );
endmodule

/* sim/tb_top.sv */
module tb_top;
    import blv_pkg::*;

    typedef struct {
        logic [1:0] op;
        logic [7:0] b;
    } cmd_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [62:0] cfg_data;

    blv_in_if  in_ch ();
    blv_out_if out_ch ();

    bed_line_validator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Byte commands waiting to be sent, and line results still due
    cmd_t pending_cmds[$];
    res_t due_lines[$];
    int   fail_count;
    int   lines_checked;
    int   send_idle_pct;
    int   recv_stall_pct;

    // Limit registers as the parser sees them
    logic [15:0] lim_line;
    logic [7:0]  lim_chrom;
    logic [4:0]  lim_digits;
    logic [62:0] lim_coord;
    logic [7:0]  lim_id;

    // Parser state mirror
    phase_t      p_phase;
    logic        p_hdr_ok;
    logic [31:0] p_line_no;
    logic [15:0] p_line_bytes;
    logic [7:0]  p_field_bytes;
    logic [63:0] p_start;
    logic [63:0] p_end;
    logic        p_non_digit;
    logic [1:0]  p_hdr_alive;
    int          p_hdr_pos;
    logic        p_hdr_hit;
    logic [4:0]  p_err;
    logic        p_halted;
    logic        p_extra;
    logic [7:0]  p_id_bytes;
    logic [7:0]  p_chrom_len;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("** bed_line_validator: FAILED **");
        $finish;
    end

    task automatic clear_line();
        p_phase = PH_CHROM;
        p_line_bytes = '0;
        p_field_bytes = '0;
        p_start = '0;
        p_end = '0;
        p_non_digit = 1'b0;
        p_hdr_alive = 2'b11;
        p_hdr_pos = 0;
        p_hdr_hit = 1'b0;
        p_err = ERR_NONE;
        p_extra = 1'b0;
        p_id_bytes = '0;
        p_chrom_len = '0;
    endtask

    task automatic bump_line();
        if (p_line_no != 32'hFFFF_FFFF)
            p_line_no = p_line_no + 1;
    endtask

    task automatic add_line(kind_t kind, logic [4:0] code, bit full);
        res_t r;
        r.line_kind = kind;
        r.error_code = code;
        r.line_number = p_line_no;
        r.chrom_length = full ? p_chrom_len : 8'd0;
        r.start_coord = full ? p_start[62:0] : 63'd0;
        r.end_coord = full ? p_end[62:0] : 63'd0;
        r.has_extra_fields = full && p_extra;
        r.id_length = (full && p_extra) ? p_id_bytes : 8'd0;
        due_lines.push_back(r);
    endtask

    function automatic logic [63:0] times_ten_add(logic [63:0] v, logic [7:0] d);
        if (v > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10)
            return 64'hFFFF_FFFF_FFFF_FFFF;
        return v * 10 + d;
    endfunction

    function automatic logic [4:0] coord_code(logic [4:0] base, logic [63:0] v);
        if (p_field_bytes > lim_digits) return base;
        if (p_field_bytes == 0) return base + 5'd1;
        if (p_non_digit) return base + 5'd2;
        if (v > {1'b0, lim_coord}) return base + 5'd3;
        return ERR_NONE;
    endfunction

    task automatic track_header(logic [7:0] b);
        if (p_hdr_hit) return;
        if (p_hdr_pos == 0 && (b == CH_HASH || b == CH_AT))
        begin
            p_hdr_hit = 1'b1;
            return;
        end
        if (p_hdr_pos < 7 && p_hdr_alive[0] && b != WORD_BROWSER[p_hdr_pos])
            p_hdr_alive[0] = 1'b0;
        if (p_hdr_pos < 5 && p_hdr_alive[1] && b != WORD_TRACK[p_hdr_pos])
            p_hdr_alive[1] = 1'b0;
        if (p_hdr_pos < 7)
            p_hdr_pos++;
        if ((p_hdr_alive[0] && p_hdr_pos == 7) || (p_hdr_alive[1] && p_hdr_pos == 5))
            p_hdr_hit = 1'b1;
    endtask

    task automatic field_byte(logic [7:0] b);
        logic [4:0] code;
        logic       sep;
        sep = (b == CH_SP || b == CH_TAB);
        track_header(b);
        if (p_err != ERR_NONE) return;
        case (p_phase)
            PH_CHROM:
            begin
                if (sep)
                begin
                    if (p_field_bytes == 0)
                        p_err = ERR_LEAD_SEP;
                    else if (p_field_bytes > lim_chrom)
                        p_err = ERR_CHROM_LONG;
                    else
                    begin
                        p_chrom_len = p_field_bytes;
                        p_phase = PH_START;
                        p_field_bytes = '0;
                    end
                end
                else if (p_field_bytes != 8'hFF)
                    p_field_bytes++;
            end
            PH_START, PH_END:
            begin
                if (sep)
                begin
                    if (p_phase == PH_START)
                    begin
                        code = coord_code(ERR_START_BASE, p_start);
                        if (code != ERR_NONE) p_err = code;
                        else p_phase = PH_END;
                    end
                    else
                    begin
                        code = coord_code(ERR_END_BASE, p_end);
                        if (code == ERR_NONE && p_end <= p_start) code = ERR_END_LE;
                        if (code != ERR_NONE) p_err = code;
                        else p_phase = PH_SKIP;
                    end
                    p_field_bytes = '0;
                    p_non_digit = 1'b0;
                end
                else
                begin
                    if (p_field_bytes != 8'hFF) p_field_bytes++;
                    if (b >= "0" && b <= "9")
                    begin
                        if (p_phase == PH_START) p_start = times_ten_add(p_start, b - "0");
                        else p_end = times_ten_add(p_end, b - "0");
                    end
                    else
                        p_non_digit = 1'b1;
                end
            end
            PH_SKIP:
            begin
                if (!(sep || b == CH_VT || b == CH_FF || b == CH_CR))
                begin
                    p_extra = 1'b1;
                    p_id_bytes = 8'd1;
                    p_phase = PH_ID;
                end
            end
            PH_ID:
            begin
                if (sep) p_phase = PH_REST;
                else if (p_id_bytes != 8'hFF) p_id_bytes++;
            end
            default: ;
        endcase
    endtask

    task automatic close_line(bit at_eof);
        logic [4:0] code;
        code = p_err;
        if (p_hdr_ok && p_hdr_hit)
        begin
            add_line(KIND_HEADER, ERR_NONE, 0);
            bump_line();
            clear_line();
            return;
        end
        if (code == ERR_NONE)
        begin
            if (p_phase == PH_CHROM) code = ERR_NO_SEP;
            else if (p_phase == PH_START) code = ERR_NO_SEP_START;
            else if (p_phase == PH_END)
            begin
                if (at_eof) code = ERR_EOF_IN_END;
                else
                begin
                    code = coord_code(ERR_END_BASE, p_end);
                    if (code == ERR_NONE && p_end <= p_start) code = ERR_END_LE;
                end
            end
        end
        if (code == ERR_NONE && p_extra && p_id_bytes > lim_id) code = ERR_ID_LONG;
        if (code != ERR_NONE)
        begin
            add_line(KIND_ERROR, code, 0);
            p_halted = 1'b1;
        end
        else
        begin
            add_line(KIND_DATA, ERR_NONE, 1);
            p_hdr_ok = 1'b0;
            bump_line();
        end
        clear_line();
    endtask

    // Expected results for one accepted byte command
    task automatic predict_lines(logic [1:0] op, logic [7:0] b);
        if (op == OP_FILE)
        begin
            clear_line();
            p_line_no = 32'd1;
            p_hdr_ok = 1'b1;
            p_halted = 1'b0;
            return;
        end
        if (op == OP_EOF)
        begin
            if (!p_halted && p_line_bytes > 0) close_line(1);
            p_halted = 1'b1;
            clear_line();
            return;
        end
        if (op == OP_NONE || p_halted) return;
        if (b == CH_NL && p_line_bytes == 0)
        begin
            add_line(KIND_BLANK, ERR_NONE, 0);
            bump_line();
            return;
        end
        p_line_bytes++;
        if (p_line_bytes >= lim_line)
        begin
            add_line(KIND_ERROR, ERR_TOO_LONG, 0);
            p_halted = 1'b1;
            clear_line();
            return;
        end
        if (b == CH_NL)
            close_line(0);
        else
            field_byte(b);
    endtask

    // Stimulus builders
    task automatic put_cmd(logic [1:0] op, logic [7:0] b);
        cmd_t c;
        c.op = op;
        c.b = b;
        pending_cmds.push_back(c);
    endtask

    task automatic put_text(string s);
        foreach (s[i])
            put_cmd(OP_DATA, s[i]);
    endtask

    task automatic put_sep();
        put_cmd(OP_DATA, ($urandom % 2) ? CH_SP : CH_TAB);
    endtask

    function automatic logic [63:0] pick_coord();
        if ($urandom % 10 == 0)
            return {$urandom, $urandom};
        return 64'($urandom_range(0, 999));
    endfunction

    task automatic put_record_line();
        logic [63:0] s;
        logic [63:0] e;
        int          n;
        logic [7:0]  bytes[$];
        string       txt;
        n = ($urandom % 8 == 0) ? $urandom_range(1, int'(lim_chrom) + 2) : $urandom_range(1, 4);
        repeat (n) bytes.push_back(8'("a" + $urandom % 26));
        bytes.push_back(($urandom % 2) ? CH_SP : CH_TAB);
        s = pick_coord();
        e = ($urandom % 10 == 0) ? pick_coord() : s + 64'($urandom_range(0, 600));
        if ($urandom % 8 == 0) bytes.push_back("0");
        txt = $sformatf("%0d", s);
        foreach (txt[i]) bytes.push_back(txt[i]);
        bytes.push_back(($urandom % 2) ? CH_SP : CH_TAB);
        txt = $sformatf("%0d", e);
        foreach (txt[i]) bytes.push_back(txt[i]);
        if ($urandom % 3 != 0)
        begin
            bytes.push_back(($urandom % 2) ? CH_SP : CH_TAB);
            if ($urandom % 3 == 0) bytes.push_back(($urandom % 2) ? CH_VT : CH_CR);
            n = ($urandom % 6 == 0) ? $urandom_range(1, 270) : $urandom_range(1, 6);
            repeat (n) bytes.push_back(8'("a" + $urandom % 26));
            if ($urandom % 2) bytes.push_back(CH_SP);
            if ($urandom % 2) bytes.push_back("x");
        end
        // Broken record: one byte replaced by anything
        if ($urandom % 5 == 0)
            bytes[$urandom_range(0, bytes.size() - 1)] = 8'($urandom_range(0, 255));
        foreach (bytes[i]) put_cmd(OP_DATA, bytes[i]);
        put_cmd(OP_DATA, CH_NL);
    endtask

    task automatic put_random_line();
        int r;
        r = $urandom % 100;
        if (r < 60)
            put_record_line();
        else if (r < 70)
            put_cmd(OP_DATA, CH_NL);
        else if (r < 78)
        begin
            case ($urandom % 5)
                0: put_text("browser x");
                1: put_text("track y");
                2: put_text("#c 1 2");
                3: put_text("@r");
                default: put_text("brow 1 2");
            endcase
            put_cmd(OP_DATA, CH_NL);
        end
        else if (r < 94)
        begin
            repeat ($urandom_range(1, 10)) put_cmd(OP_DATA, 8'($urandom_range(0, 255)));
            put_cmd(OP_DATA, CH_NL);
        end
        else
            put_cmd(2'($urandom_range(OP_FILE, OP_NONE)), 8'($urandom_range(0, 255)));
    endtask

    task automatic put_random_file();
        put_cmd(OP_FILE, 8'($urandom_range(0, 255)));
        if ($urandom % 3 == 0)
        begin
            put_text(($urandom % 2) ? "track name=a" : "# comment");
            put_cmd(OP_DATA, CH_NL);
        end
        repeat ($urandom_range(1, 6)) put_random_line();
        case ($urandom % 4)
            0: put_cmd(OP_EOF, 8'($urandom_range(0, 255)));
            1:
            begin
                put_text("c 1 2");
                put_cmd(OP_EOF, 8'h00);
            end
            default: ;
        endcase
    endtask

    task automatic put_directed();
        put_cmd(OP_FILE, 8'h00);
        put_text("browser junk\n");
        put_text("track\n");
        put_text("#x\n");
        put_text("\n");
        put_text("chr1\t0 10\n");
        put_text("#late 1 2\n");
        put_text("c 5 3\n");
        put_text("x\n");
        put_cmd(OP_EOF, 8'hFF);
        put_cmd(OP_EOF, 8'h00);
        put_cmd(OP_FILE, 8'h00);
        put_text(" lead\n");
        put_cmd(OP_FILE, 8'h00);
        repeat (300) put_cmd(OP_DATA, "a");
        put_text(" 1 2\n");
        put_cmd(OP_FILE, 8'h00);
        put_text("c 99999999999999999999 1\n");
        put_cmd(OP_FILE, 8'h00);
        put_text("c 1 2 idfield extra\n");
        put_text("c 1");
        put_cmd(OP_EOF, 8'h00);
        put_cmd(OP_NONE, 8'hFF);
        put_cmd(OP_FILE, 8'h00);
        put_text("c 1 9223372036854775807\n");
        put_text("c 1 9223372036854775808\n");
        put_cmd(OP_FILE, 8'h00);
        put_text("c 1a 2\n");
        put_cmd(OP_FILE, 8'h00);
        put_text("c\n");
        put_cmd(OP_FILE, 8'h00);
        put_text("c 1\n");
        put_cmd(OP_FILE, 8'h00);
        put_text("c  1 2\n");
        put_cmd(OP_FILE, 8'h00);
        put_text("c 1 2");
        put_cmd(OP_FILE, 8'h00);
        put_cmd(OP_DATA, 8'h00);
        put_text(" 1 2 \v\rid\n");
    endtask

    task automatic write_limit(logic [2:0] idx, logic [62:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_LINE:  lim_line = val[15:0];
            CFG_CHROM: lim_chrom = val[7:0];
            CFG_DIG:   lim_digits = val[4:0];
            CFG_COORD: lim_coord = val;
            CFG_ID:    lim_id = val[7:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_all();
        while (pending_cmds.size() > 0 || in_ch.valid || due_lines.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Sender: present queued commands with random gaps, predict on transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_lines(in_ch.opcode, in_ch.data_byte);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_ch.opcode <= pending_cmds[0].op;
                    in_ch.data_byte <= pending_cmds[0].b;
                    in_ch.valid <= 1'b1;
                    void'(pending_cmds.pop_front());
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, compare each transfer to the oldest line due
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (out_ch.valid && out_ch.ready)
            begin
                if (due_lines.size() == 0)
                begin
                    $error("unexpected line result, line_number %0d", out_ch.line_number);
                    fail_count++;
                end
                else
                begin
                    if (out_ch.line_kind !== due_lines[0].line_kind)
                    begin
                        $error("line_kind exp %0d got %0d", due_lines[0].line_kind,
                            out_ch.line_kind);
                        fail_count++;
                    end
                    if (out_ch.error_code !== due_lines[0].error_code)
                    begin
                        $error("error_code exp %0d got %0d", due_lines[0].error_code,
                            out_ch.error_code);
                        fail_count++;
                    end
                    if (out_ch.line_number !== due_lines[0].line_number)
                    begin
                        $error("line_number exp %0d got %0d", due_lines[0].line_number,
                            out_ch.line_number);
                        fail_count++;
                    end
                    if (out_ch.chrom_length !== due_lines[0].chrom_length)
                    begin
                        $error("chrom_length exp %0d got %0d", due_lines[0].chrom_length,
                            out_ch.chrom_length);
                        fail_count++;
                    end
                    if (out_ch.start_coord !== due_lines[0].start_coord)
                    begin
                        $error("start_coord exp %0d got %0d", due_lines[0].start_coord,
                            out_ch.start_coord);
                        fail_count++;
                    end
                    if (out_ch.end_coord !== due_lines[0].end_coord)
                    begin
                        $error("end_coord exp %0d got %0d", due_lines[0].end_coord,
                            out_ch.end_coord);
                        fail_count++;
                    end
                    if (out_ch.has_extra_fields !== due_lines[0].has_extra_fields)
                    begin
                        $error("has_extra_fields exp %0d got %0d",
                            due_lines[0].has_extra_fields, out_ch.has_extra_fields);
                        fail_count++;
                    end
                    if (out_ch.id_length !== due_lines[0].id_length)
                    begin
                        $error("id_length exp %0d got %0d", due_lines[0].id_length,
                            out_ch.id_length);
                        fail_count++;
                    end
                    void'(due_lines.pop_front());
                    lines_checked++;
                end
            end
        end
    end

    // Main sequence: reset, then one limit setting per phase
    initial
    begin
        int target;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_NONE;
        in_ch.data_byte = '0;
        out_ch.ready = 1'b0;
        fail_count = 0;
        lines_checked = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        lim_line = 16'd4096;
        lim_chrom = 8'd127;
        lim_digits = 5'd19;
        lim_coord = 63'h7FFF_FFFF_FFFF_FFFF;
        lim_id = 8'd255;
        clear_line();
        p_hdr_ok = 1'b1;
        p_line_no = 32'd1;
        p_halted = 1'b0;
        repeat (6) @(posedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                1:
                begin
                    write_limit(CFG_LINE, 63'd30);
                    write_limit(CFG_CHROM, 63'd3);
                    write_limit(CFG_DIG, 63'd3);
                    write_limit(CFG_COORD, 63'd500);
                    write_limit(CFG_ID, 63'd3);
                end
                2:
                begin
                    write_limit(CFG_LINE, 63'd65535);
                    write_limit(CFG_CHROM, 63'd255);
                    write_limit(CFG_DIG, 63'd19);
                    write_limit(CFG_COORD, 63'h7FFF_FFFF_FFFF_FFFF);
                    write_limit(CFG_ID, 63'd255);
                end
                3:
                begin
                    write_limit(CFG_LINE, 63'd2);
                    write_limit(CFG_CHROM, 63'd1);
                    write_limit(CFG_DIG, 63'd1);
                    write_limit(CFG_COORD, 63'd0);
                    write_limit(CFG_ID, 63'd1);
                end
                4:
                begin
                    write_limit(CFG_LINE, 63'd64);
                    write_limit(CFG_CHROM, 63'd1);
                    write_limit(CFG_DIG, 63'd1);
                    write_limit(CFG_COORD, 63'd9);
                    write_limit(CFG_ID, 63'd1);
                end
                5:
                begin
                    write_limit(CFG_LINE, 63'd4096);
                    write_limit(CFG_CHROM, 63'd127);
                    write_limit(CFG_DIG, 63'd19);
                    write_limit(CFG_COORD, 63'd1000000);
                    write_limit(CFG_ID, 63'd10);
                end
                default: ;
            endcase
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 20 : 68) : 0;
            recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 20 : 68) : 0;
            if (ph == 0)
                put_directed();
            target = pending_cmds.size() + ((ph == 3) ? 20 : 50);
            while (pending_cmds.size() < target)
                put_random_file();
            drain_all();
        end

        $display("checked %0d line results over six limit settings and four idle patterns",
            lines_checked);
        if (fail_count == 0)
            $display("** bed_line_validator: PASSED **");
        else
            $display("** bed_line_validator: FAILED **");
        $finish;
    end
endmodule
